/* src/bctd_pkg.sv */
// Shared types and constants for the DXT1/DXT3/DXT5 block decoder.
// No dependencies; every other file in src imports this package.
package bctd_pkg;

  localparam int MAX_DIM = 8192;
  localparam int TEXELS  = 16;

  // format register codes
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [63:0] color_bits;
    logic [63:0] alpha_bits;
    logic [10:0] block_col;
    logic [10:0] block_row;
  } in_t;

  typedef struct packed {
    logic [12:0] texel_x;
    logic [12:0] texel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // palette numerators, channel 0 red, 1 green, 2 blue
  typedef struct packed {
    logic [2:0][7:0]  e0;
    logic [2:0][7:0]  e1;
    logic [2:0][9:0]  cn2;
    logic [2:0][9:0]  cn3;
    logic             punch;
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic             a_gt;
    logic [5:0][10:0] an7;
    logic [3:0][10:0] an5;
  } pnum_t;

  typedef struct packed {
    logic [3:0][2:0][7:0] rgb;
    logic [7:0]           a3;
  } cpal_t;

  typedef logic [7:0][7:0] apal_t;

  typedef struct packed {
    logic [TEXELS-1:0] mask;
    logic [10:0]       block_col;
    logic [10:0]       block_row;
  } blk_t;

  typedef struct packed {
    logic empty;
    logic load_ready;
  } m_stat_t;

endpackage

/* src/bctd_palette.sv */
// Color and alpha palette builder: divides the registered numerators by
// 3, 5 and 7 through reciprocal multiplies. Depends on bctd_pkg.
module bctd_palette import bctd_pkg::*; (
  input  pnum_t num,
  output cpal_t cpal,
  output apal_t apal
);

  // exact for x < 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  // exact for x < 1792
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd2341;
    return p[21:14];
  endfunction

  // exact for x < 1280
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd3277;
    return p[21:14];
  endfunction

  logic [2:0][8:0] avg;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      avg[ch] = 9'(num.e0[ch]) + 9'(num.e1[ch]) + 9'd1;
      cpal.rgb[0][ch] = num.e0[ch];
      cpal.rgb[1][ch] = num.e1[ch];
      if (num.punch) begin
        cpal.rgb[2][ch] = avg[ch][8:1];
        cpal.rgb[3][ch] = 8'd0;
      end else begin
        cpal.rgb[2][ch] = div3(num.cn2[ch]);
        cpal.rgb[3][ch] = div3(num.cn3[ch]);
      end
    end
    cpal.a3 = num.punch ? 8'd0 : 8'd255;

    apal[0] = num.a0;
    apal[1] = num.a1;
    if (num.a_gt) begin
      for (int k = 0; k < 6; k++) apal[k+2] = div7(num.an7[k]);
    end else begin
      for (int k = 0; k < 4; k++) apal[k+2] = div5(num.an5[k]);
      apal[6] = 8'd0;
      apal[7] = 8'd255;
    end
  end

endmodule

/* src/bctd_lane.sv */
// One texel lane: looks up color and alpha for a single texel from the
// block palettes, or in DXT3 alpha from its own nibble. Depends on bctd_pkg.
module bctd_lane import bctd_pkg::*; (
  input  logic [1:0] fmt,
  input  cpal_t      cpal,
  input  apal_t      apal,
  input  logic [1:0] ci,
  input  logic [3:0] anib,
  input  logic [2:0] aidx,
  output rgba_t      texel
);

  always_comb begin
    texel.red   = cpal.rgb[ci][0];
    texel.green = cpal.rgb[ci][1];
    texel.blue  = cpal.rgb[ci][2];
    case (fmt)
      FMT_DXT1: texel.alpha = (ci == 2'd3) ? cpal.a3 : 8'd255;
      FMT_DXT3: texel.alpha = {anib, anib};  // nibble times 17
      default:  texel.alpha = apal[aidx];
    endcase
  end

endmodule

/* src/bctd_merge.sv */
// Merge stage: holds the sixteen lane results of one block and sends the
// unclipped ones in row order, one per cycle as out_ready allows. Depends on bctd_pkg.
module bctd_merge import bctd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   ld_valid,
  input  blk_t                   ld_blk,
  input  rgba_t [TEXELS-1:0]     ld_texels,
  output m_stat_t                stat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_t                   out_data
);

  logic [TEXELS-1:0]  mask_r, mask_nxt;
  logic [10:0]        col_r, row_r;
  rgba_t [TEXELS-1:0] tex_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic              emit, load_ok, load;
  logic [TEXELS-1:0] sel, rest;
  rgba_t             pick;
  logic [3:0]        pick_idx;

  always_comb begin
    emit    = (mask_r != '0) && (!out_valid_r || out_ready);
    sel     = mask_r & (~mask_r + TEXELS'(1));
    rest    = mask_r & ~sel;
    load_ok = (mask_r == '0) || (emit && (rest == '0));
    load    = ld_valid && load_ok;

    pick     = '0;
    pick_idx = '0;
    for (int i = 0; i < TEXELS; i++) begin
      if (sel[i]) begin
        pick     = pick | tex_r[i];
        pick_idx = pick_idx | 4'(i);
      end
    end

    if (load)      mask_nxt = ld_blk.mask;
    else if (emit) mask_nxt = rest;
    else           mask_nxt = mask_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tex_r <= ld_texels;
      col_r <= ld_blk.block_col;
      row_r <= ld_blk.block_row;
    end
    if (emit) begin
      out_data_r.texel_x <= {col_r, pick_idx[1:0]};
      out_data_r.texel_y <= {row_r, pick_idx[3:2]};
      out_data_r.red     <= pick.red;
      out_data_r.green   <= pick.green;
      out_data_r.blue    <= pick.blue;
      out_data_r.alpha   <= pick.alpha;
      out_data_r.last    <= (rest == '0);
    end
  end

  assign stat.empty      = (mask_r == '0);
  assign stat.load_ready = load_ok;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

/* src/bc_texture_block_decoder_core.sv */
// DXT1/DXT3/DXT5 block decoder top level: config registers, numerator
// and palette stages, sixteen texel lanes and the merge stage.
// Depends on bctd_pkg, bctd_palette, bctd_lane, bctd_merge.
//
//  - Input (in_valid/in_ready/in_data): one compressed 4x4 block per
//    request with its block column and row.
//  - Result (out_valid/out_ready/out_data): the block's texels inside the
//    image, row by row, as RGBA8 with image coordinates; last marks the
//    final texel of the block. Fully clipped blocks return nothing.
//  - Config (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; write
//    format, width and height only while idle. Unknown indexes are dropped.
//  - Path: an accepted request passes the numerator stage, palette stage,
//    block buffer and output reg before its first texel shows on out_valid.
//  - Throughput: one texel per cycle while out_ready allows; the buffer
//    reloads as its last texel leaves, so blocks stream without gaps.
//  - Stalls: out_ready low holds the output register and the buffer; in_ready
//    drops once both stages are full and merge is busy. Up to four blocks in flight.
//  - Reset (rst_n low, synchronous) empties the pipeline and sets format
//    to DXT1 and the image size to 1x1.
module bc_texture_block_decoder_core import bctd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  // config registers
  logic [1:0]  format_r;
  logic [13:0] width_r, height_r;
  logic [13:0] w_eff, h_eff;

  // stage A: palette numerators and clip mask
  logic              a_valid_r;
  pnum_t             a_num_r;
  in_t               a_item_r;
  logic [TEXELS-1:0] a_mask_r;

  // stage B: finished palettes
  logic              b_valid_r;
  cpal_t             b_cpal_r;
  apal_t             b_apal_r;
  in_t               b_item_r;
  logic [TEXELS-1:0] b_mask_r;

  logic              a_ready, b_ready;
  pnum_t             num_nxt;
  logic [TEXELS-1:0] mask_nxt;
  cpal_t             pal_c;
  apal_t             pal_a;
  rgba_t [TEXELS-1:0] lane_tex;
  blk_t              m_blk;
  m_stat_t           m_stat;

  logic [15:0]       c0, c1;
  logic [12:0]       tx, ty;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // sizes above the addressable range clip like MAX_DIM
  assign w_eff = (width_r  > 14'(MAX_DIM)) ? 14'(MAX_DIM) : width_r;
  assign h_eff = (height_r > 14'(MAX_DIM)) ? 14'(MAX_DIM) : height_r;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r <= FMT_DXT1;
      width_r  <= 14'd1;
      height_r <= 14'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FORMAT: format_r <= cfg_data[1:0];
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- handshake chain ----------------
  assign b_ready  = !b_valid_r || m_stat.load_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  // ---------------- stage A numerators ----------------
  always_comb begin
    c0 = in_data.color_bits[15:0];
    c1 = in_data.color_bits[31:16];

    num_nxt.e0[0] = expand5(c0[15:11]);
    num_nxt.e0[1] = expand6(c0[10:5]);
    num_nxt.e0[2] = expand5(c0[4:0]);
    num_nxt.e1[0] = expand5(c1[15:11]);
    num_nxt.e1[1] = expand6(c1[10:5]);
    num_nxt.e1[2] = expand5(c1[4:0]);
    for (int ch = 0; ch < 3; ch++) begin
      num_nxt.cn2[ch] = {1'b0, num_nxt.e0[ch], 1'b0} + 10'(num_nxt.e1[ch]) + 10'd1;
      num_nxt.cn3[ch] = 10'(num_nxt.e0[ch]) + {1'b0, num_nxt.e1[ch], 1'b0} + 10'd1;
    end
    // punch-through only in DXT1 with c0 <= c1
    num_nxt.punch = (format_r == FMT_DXT1) && (c0 <= c1);

    num_nxt.a0   = in_data.alpha_bits[7:0];
    num_nxt.a1   = in_data.alpha_bits[15:8];
    num_nxt.a_gt = num_nxt.a0 > num_nxt.a1;
    for (int k = 0; k < 6; k++) begin
      num_nxt.an7[k] = 11'(6 - k) * 11'(num_nxt.a0) + 11'(k + 1) * 11'(num_nxt.a1)
                       + 11'd3;
    end
    for (int k = 0; k < 4; k++) begin
      num_nxt.an5[k] = 11'(4 - k) * 11'(num_nxt.a0) + 11'(k + 1) * 11'(num_nxt.a1)
                       + 11'd2;
    end

    // clip against the right and bottom edges
    for (int t = 0; t < TEXELS; t++) begin
      tx = {in_data.block_col, 2'(t)};
      ty = {in_data.block_row, 2'(t >> 2)};
      mask_nxt[t] = ({1'b0, tx} < w_eff) && ({1'b0, ty} < h_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_num_r  <= num_nxt;
      a_item_r <= in_data;
      a_mask_r <= mask_nxt;
    end
  end

  // ---------------- stage B palettes ----------------
  bctd_palette u_palette (
    .num  (a_num_r),
    .cpal (pal_c),
    .apal (pal_a)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r && b_ready) begin
      b_cpal_r <= pal_c;
      b_apal_r <= pal_a;
      b_item_r <= a_item_r;
      b_mask_r <= a_mask_r;
    end
  end

  // ---------------- texel lanes ----------------
  for (genvar t = 0; t < TEXELS; t++) begin : g_lane
    bctd_lane u_lane (
      .fmt   (format_r),
      .cpal  (b_cpal_r),
      .apal  (b_apal_r),
      .ci    (b_item_r.color_bits[32 + 2*t +: 2]),
      .anib  (b_item_r.alpha_bits[4*t +: 4]),
      .aidx  (b_item_r.alpha_bits[16 + 3*t +: 3]),
      .texel (lane_tex[t])
    );
  end

  // ---------------- merge / output ----------------
  assign m_blk.mask      = b_mask_r;
  assign m_blk.block_col = b_item_r.block_col;
  assign m_blk.block_row = b_item_r.block_row;

  bctd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_valid  (b_valid_r),
    .ld_blk    (m_blk),
    .ld_texels (lane_tex),
    .stat      (m_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // ---------------- assertions ----------------
  // a texel that is not the block's last leaves the rest of its block buffered
  a_rest_buffered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> !m_stat.empty)
    else $error("non-last texel shown with an empty block buffer");

  // nothing outside the configured image is emitted
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (({1'b0, out_data.texel_x} < w_eff) && ({1'b0, out_data.texel_y} < h_eff)))
    else $error("texel outside the image emitted");

  // input backpressure only when both pipeline stages are full and merge is busy
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (a_valid_r && b_valid_r && !m_stat.load_ready))
    else $error("in_ready low with room in the pipeline");

  // a block held in stage B moves on once the merge stage can take it
  a_b_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && m_stat.load_ready && !a_valid_r) |=> !b_valid_r)
    else $error("stage B did not advance");

endmodule
